// ----- rtl/core/sem_pkg.sv -----
package sem_pkg;

    // Defaults for the top level geometry parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration register widths, reset values and indexes
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Pixel and arithmetic widths
    localparam int COLOR_W    = 8;
    localparam int PIX_W      = 3 * COLOR_W;
    localparam int GRAD_W     = 10;              // |gx|, |gy| <= 1020
    localparam int SUM_W      = 2 * GRAD_W + 1;  // gx^2 + gy^2
    localparam int ROOT_IN_W  = 16;              // sums at or above 2^16 saturate
    localparam int ROOT_W     = 8;
    localparam int ROOT_STEPS = ROOT_IN_W / 2;

    // Red sits in the low byte of a beat
    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } rgb_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_GRAD,
        ST_SQ,
        ST_ROOT_GO,
        ST_ROOT,
        ST_OUT
    } sem_state_t;

    // (11*r + 16*g + 5*b) >> 5
    function automatic logic [COLOR_W-1:0] gray_of(input rgb_t p);
        logic [COLOR_W+4:0] acc;
        acc = (13'(p.red) << 3) + (13'(p.red) << 1) + 13'(p.red)
            + (13'(p.green) << 4)
            + (13'(p.blue) << 2) + 13'(p.blue);
        return acc[COLOR_W+4:5];
    endfunction

endpackage

// ----- rtl/core/sobel_edge_magnitude_unit.sv -----
// Channel   Ports                        Beat contents (low bit first)
// ------    ---------------------------  ------------------------------------------
// input     s_tvalid s_tready s_tdata    tdata: red[7:0] green[15:8] blue[23:16]
//           s_tuser                      tuser: action (1 = flush beat, black pixel)
// output    m_tvalid m_tready m_tdata    tdata: out_red out_green out_blue
//           m_tuser m_tlast              tuser: out_valid, out_is_border; tlast: last
// config    cfg_valid cfg_ready          cfg_index 0 frame_width, 1 frame_height
//           cfg_index cfg_data
//
// One input beat is worked at a time: the next beat is accepted only after
// the result has been loaded into the output register, once that register is free.
// In between, the beat passes the line store read, the window update and write
// back, the gradients, the squares and the 8 iterations of the square root unit.
// Reset (aresetn low, synchronous) clears state, position, priming and the output
// valid; the line store and the output data are not cleared. A stalled m_tready holds the result
// in the output register while the next input beat is already being worked.
module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sem_pkg::PIX_W-1:0]        s_tdata,   // red, green, blue
    input  logic                             s_tuser,   // action

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sem_pkg::PIX_W-1:0]        m_tdata,   // out_red, out_green, out_blue
    output logic [1:0]                       m_tuser,   // out_valid, out_is_border
    output logic                             m_tlast,   // last_of_frame

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Index and geometry widths
    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int ROWW = $clog2(MAX_HEIGHT);
    localparam int WVW  = ($clog2(MAX_WIDTH + 1) > sem_pkg::FW_W) ?
                          $clog2(MAX_WIDTH + 1) : sem_pkg::FW_W;
    localparam int HVW  = ($clog2(MAX_HEIGHT + 1) > sem_pkg::FH_W) ?
                          $clog2(MAX_HEIGHT + 1) : sem_pkg::FH_W;
    localparam int CW   = sem_pkg::COLOR_W;
    localparam int GW   = sem_pkg::GRAD_W;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [sem_pkg::FW_W-1:0] frame_width_reg;
    logic [sem_pkg::FH_W-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= sem_pkg::FW_RESET;
            frame_height_reg <= sem_pkg::FH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sem_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_data[sem_pkg::FW_W-1:0];
                end
                sem_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_data[sem_pkg::FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Geometry clamped to [3, MAX]
    logic [WVW-1:0] w_raw, w_eff;
    logic [HVW-1:0] h_raw, h_eff;

    assign w_raw = WVW'(frame_width_reg);
    assign h_raw = HVW'(frame_height_reg);

    always_comb begin
        if (w_raw < WVW'(3)) begin
            w_eff = WVW'(3);
        end else if (w_raw > WVW'(MAX_WIDTH)) begin
            w_eff = WVW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw < HVW'(3)) begin
            h_eff = HVW'(3);
        end else if (h_raw > HVW'(MAX_HEIGHT)) begin
            h_eff = HVW'(MAX_HEIGHT);
        end else begin
            h_eff = h_raw;
        end
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    sem_pkg::sem_state_t state_reg, state_next;

    logic in_accept;
    logic root_start;
    logic root_busy;
    logic out_load;
    logic m_tvalid_reg;

    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sem_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sem_pkg::ST_WIN;
                end
            end
            sem_pkg::ST_WIN:     state_next = sem_pkg::ST_GRAD;
            sem_pkg::ST_GRAD:    state_next = sem_pkg::ST_SQ;
            sem_pkg::ST_SQ:      state_next = sem_pkg::ST_ROOT_GO;
            sem_pkg::ST_ROOT_GO: state_next = sem_pkg::ST_ROOT;
            sem_pkg::ST_ROOT: begin
                if (!root_busy) begin
                    state_next = sem_pkg::ST_OUT;
                end
            end
            sem_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = sem_pkg::ST_IDLE;
                end
            end
            default:             state_next = sem_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            sem_pkg::ST_IDLE:    s_tready   = 1'b1;
            sem_pkg::ST_ROOT_GO: root_start = 1'b1;
            sem_pkg::ST_OUT:     out_load   = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sem_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Raster position
    // ---------------------------------------------------------------
    logic [COLW-1:0] col_cnt_reg, col_cnt_next;
    logic [ROWW-1:0] row_cnt_reg, row_cnt_next;
    logic [COLW-1:0] col_reg;       // clamped position of the beat in work
    logic [ROWW-1:0] row_reg;
    logic [COLW-1:0] col_eff;
    logic [ROWW-1:0] row_eff;

    // A position left past a shrunk geometry wraps to zero
    assign col_eff = (WVW'(col_cnt_reg) >= w_eff) ? '0 : col_cnt_reg;
    assign row_eff = (HVW'(row_cnt_reg) >= h_eff) ? '0 : row_cnt_reg;

    logic [WVW-1:0] col_inc;
    logic [HVW-1:0] row_inc;

    assign col_inc = WVW'(col_reg) + WVW'(1);
    assign row_inc = HVW'(row_reg) + HVW'(1);

    always_comb begin
        if (col_inc >= w_eff) begin
            col_cnt_next = '0;
            row_cnt_next = (row_inc >= h_eff) ? '0 : row_inc[ROWW-1:0];
        end else begin
            col_cnt_next = col_inc[COLW-1:0];
            row_cnt_next = row_reg;
        end
    end

    // Output position: one line plus one pixel behind the input
    logic [WVW-1:0]   ox;
    logic [HVW-1:0]   oy;
    logic [HVW:0]     oy_wrap;
    logic             primes;

    assign oy_wrap = (HVW+1)'(row_reg) + (HVW+1)'(h_eff) - (HVW+1)'(2);

    always_comb begin
        if (col_reg != '0) begin
            ox = WVW'(col_reg) - WVW'(1);
            oy = (row_reg != '0) ? HVW'(row_reg) - HVW'(1) : h_eff - HVW'(1);
        end else begin
            ox = w_eff - WVW'(1);
            oy = (row_reg >= ROWW'(2)) ? HVW'(row_reg) - HVW'(2) : oy_wrap[HVW-1:0];
        end
    end

    assign primes = (row_reg >= ROWW'(2)) || ((row_reg == ROWW'(1)) && (col_reg != '0));

    logic primed_reg;
    logic border_reg;
    logic last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            primed_reg  <= 1'b0;
        end else if (state_reg == sem_pkg::ST_WIN) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (primes) begin
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            col_reg <= col_eff;
            row_reg <= row_eff;
        end
        if (state_reg == sem_pkg::ST_WIN) begin
            border_reg <= (ox == '0) || (ox == w_eff - WVW'(1))
                       || (oy == '0) || (oy == h_eff - HVW'(1));
            last_reg   <= (ox == w_eff - WVW'(1)) && (oy == h_eff - HVW'(1));
        end
    end

    // ---------------------------------------------------------------
    // Line store: two lines, read at acceptance, written back in the
    // following cycle at the same address. Only one beat is in work, so
    // a read never meets a pending write to the same entry.
    // ---------------------------------------------------------------
    sem_pkg::rgb_t line_mid_mem [MAX_WIDTH];
    sem_pkg::rgb_t line_top_mem [MAX_WIDTH];
    sem_pkg::rgb_t mid_rd_reg;
    sem_pkg::rgb_t top_rd_reg;
    sem_pkg::rgb_t pix_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mid_rd_reg <= line_mid_mem[col_eff];
            top_rd_reg <= line_top_mem[col_eff];
            pix_reg    <= s_tuser ? sem_pkg::rgb_t'('0) : sem_pkg::rgb_t'(s_tdata);
        end
        if (state_reg == sem_pkg::ST_WIN) begin
            line_top_mem[col_reg] <= mid_rd_reg;
            line_mid_mem[col_reg] <= pix_reg;
        end
    end

    // ---------------------------------------------------------------
    // 3x3 window: gray values for the kernels, RGB of the middle row
    // for border pass-through. Row 0 is the top, column 0 the oldest.
    // ---------------------------------------------------------------
    logic [CW-1:0]  gray_win_reg [3][3];
    sem_pkg::rgb_t  rgb_mid_reg  [2];

    always_ff @(posedge aclk) begin
        if (state_reg == sem_pkg::ST_WIN) begin
            for (int k = 0; k < 3; k++) begin
                gray_win_reg[k][0] <= gray_win_reg[k][1];
                gray_win_reg[k][1] <= gray_win_reg[k][2];
            end
            gray_win_reg[0][2] <= sem_pkg::gray_of(top_rd_reg);
            gray_win_reg[1][2] <= sem_pkg::gray_of(mid_rd_reg);
            gray_win_reg[2][2] <= sem_pkg::gray_of(pix_reg);
            rgb_mid_reg[0]     <= rgb_mid_reg[1];
            rgb_mid_reg[1]     <= mid_rd_reg;
        end
    end

    // ---------------------------------------------------------------
    // Gradients, squares, root
    // ---------------------------------------------------------------
    logic [GW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic [GW-1:0] gx_abs_reg, gy_abs_reg;
    logic [sem_pkg::SUM_W-1:0] sum_reg;

    assign gx_pos = GW'(gray_win_reg[0][2]) + (GW'(gray_win_reg[1][2]) << 1)
                  + GW'(gray_win_reg[2][2]);
    assign gx_neg = GW'(gray_win_reg[0][0]) + (GW'(gray_win_reg[1][0]) << 1)
                  + GW'(gray_win_reg[2][0]);
    assign gy_pos = GW'(gray_win_reg[0][0]) + (GW'(gray_win_reg[0][1]) << 1)
                  + GW'(gray_win_reg[0][2]);
    assign gy_neg = GW'(gray_win_reg[2][0]) + (GW'(gray_win_reg[2][1]) << 1)
                  + GW'(gray_win_reg[2][2]);

    always_ff @(posedge aclk) begin
        if (state_reg == sem_pkg::ST_GRAD) begin
            gx_abs_reg <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
            gy_abs_reg <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        end
        if (state_reg == sem_pkg::ST_SQ) begin
            sum_reg <= sem_pkg::SUM_W'(gx_abs_reg) * sem_pkg::SUM_W'(gx_abs_reg)
                     + sem_pkg::SUM_W'(gy_abs_reg) * sem_pkg::SUM_W'(gy_abs_reg);
        end
    end

    logic [sem_pkg::ROOT_W-1:0] root;
    logic [CW-1:0]              mag;

    sem_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (sum_reg[sem_pkg::ROOT_IN_W-1:0]),
        .busy    (root_busy),
        .root    (root)
    );

    // Sums of 2^16 and more have a root above 255
    assign mag = (sum_reg[sem_pkg::SUM_W-1:sem_pkg::ROOT_IN_W] != '0) ? '1 : CW'(root);

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    sem_pkg::rgb_t out_pix_reg;
    logic [1:0]    out_user_reg;
    logic          out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (!primed_reg) begin
                out_pix_reg  <= '0;
                out_user_reg <= 2'b00;
                out_last_reg <= 1'b0;
            end else begin
                if (border_reg) begin
                    out_pix_reg <= rgb_mid_reg[0];
                end else begin
                    out_pix_reg <= '{blue: mag, green: mag, red: mag};
                end
                out_user_reg <= {border_reg, 1'b1};
                out_last_reg <= last_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/core/sem_isqrt.sv -----
// Digit-by-digit integer square root, one result bit per cycle.
module sem_isqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [sem_pkg::ROOT_IN_W-1:0]  operand,
    output logic                           busy,
    output logic [sem_pkg::ROOT_W-1:0]     root
);

    localparam int STEP_W = $clog2(sem_pkg::ROOT_STEPS);

    logic [sem_pkg::ROOT_IN_W-1:0] rem_reg;
    logic [sem_pkg::ROOT_IN_W-1:0] res_reg;
    logic [sem_pkg::ROOT_IN_W-1:0] bit_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          busy_reg;

    logic [sem_pkg::ROOT_IN_W:0]   trial;
    logic                          take;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take  = {1'b0, rem_reg} >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(sem_pkg::ROOT_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= operand;
            res_reg <= '0;
            bit_reg <= sem_pkg::ROOT_IN_W'(1) << (sem_pkg::ROOT_IN_W - 2);
        end else if (busy_reg) begin
            if (take) begin
                rem_reg <= rem_reg - trial[sem_pkg::ROOT_IN_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[sem_pkg::ROOT_W-1:0];

endmodule
